// ===== rtl/core/gfalu_pkg.sv =====
package gfalu_pkg;

    // Operation select codes carried by the func field.
    typedef enum logic [1:0] {
        FUNC_ADD  = 2'd0,
        FUNC_MUL  = 2'd1,
        FUNC_INV  = 2'd2,
        FUNC_SBOX = 2'd3
    } func_t;

    // Sequencer states of the arithmetic core.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_MULT,
        ST_SQR,
        ST_FINAL,
        ST_DONE
    } state_t;

    // Status and result that the core hands to the output stage.
    typedef struct packed {
        logic       busy;
        logic       done;
        logic [7:0] data;
    } resp_t;

    // Low byte of the reduction polynomial x^8+x^4+x^3+x+1.
    localparam logic [7:0] PolyLow = 8'h1B;
    // Exponent that maps a nonzero element to its inverse.
    localparam logic [7:0] InvExp = 8'hFE;
    // Additive constant of the AES affine map.
    localparam logic [7:0] AffineConst = 8'h63;

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
        logic [15:0] dbl;
        dbl = {v, v} << n;
        return dbl[15:8];
    endfunction

    function automatic logic [7:0] aes_affine(input logic [7:0] v);
        return v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4) ^ AffineConst;
    endfunction

endpackage

// ===== rtl/core/gfalu_mul.sv =====
module gfalu_mul (
    input  logic [7:0] mul_a,
    input  logic [7:0] mul_b,
    output logic [7:0] product
);
    import gfalu_pkg::*;

    // Shift-and-add multiply with reduction after each doubling.
    always_comb
    begin
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = mul_a;
        for (int i = 0; i < 8; i++)
        begin
            if (mul_b[i])
            begin
                acc = acc ^ x;
            end
            x = x[7] ? ({x[6:0], 1'b0} ^ PolyLow) : {x[6:0], 1'b0};
        end
        product = acc;
    end

endmodule

// ===== rtl/core/gfalu_core.sv =====
module gfalu_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  gfalu_pkg::func_t    func,
    input  logic [7:0]          operand_a,
    input  logic [7:0]          operand_b,
    input  logic                ack,
    output gfalu_pkg::resp_t    resp
);
    import gfalu_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] k_reg;
    logic [2:0] k_next;
    logic [2:0] k_inc;
    func_t      func_reg;
    logic [7:0] a_reg;
    logic [7:0] b_reg;
    logic [7:0] r_reg;
    logic [7:0] p_reg;
    logic [7:0] res_reg;
    logic [7:0] res_next;
    logic [7:0] inv_val;
    logic [7:0] mul_a;
    logic [7:0] mul_b;
    logic [7:0] product;

    gfalu_mul u_mul (
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .product (product)
    );

    assign k_inc = k_reg + 3'd1;

    // Next-state logic. The exponent is walked from its low bit: an optional
    // multiply into the running result, then a square of the running power.
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                k_next = 3'd0;
                if (start)
                begin
                    if (func inside {FUNC_ADD, FUNC_MUL})
                    begin
                        state_next = ST_SINGLE;
                    end
                    else
                    begin
                        state_next = InvExp[0] ? ST_MULT : ST_SQR;
                    end
                end
            end
            ST_SINGLE:
            begin
                state_next = ST_FINAL;
            end
            ST_MULT:
            begin
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                if (k_reg == 3'd7)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = InvExp[k_inc] ? ST_MULT : ST_SQR;
                end
            end
            ST_FINAL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic: operand selection for the shared multiplier and status.
    always_comb
    begin
        mul_a = p_reg;
        mul_b = p_reg;
        case (state_reg)
            ST_SINGLE:
            begin
                mul_a = a_reg;
                mul_b = b_reg;
            end
            ST_MULT:
            begin
                mul_a = r_reg;
                mul_b = p_reg;
            end
            default:
            begin
                mul_a = p_reg;
                mul_b = p_reg;
            end
        endcase
        resp.busy = (state_reg != ST_IDLE);
        resp.done = (state_reg == ST_DONE);
        resp.data = res_reg;
    end

    assign inv_val = (a_reg == 8'h00) ? 8'h00 : r_reg;

    always_comb
    begin
        res_next = res_reg;
        case (state_reg)
            ST_SINGLE:
            begin
                res_next = (func_reg == FUNC_ADD) ? (a_reg ^ b_reg) : product;
            end
            ST_FINAL:
            begin
                if (func_reg == FUNC_INV)
                begin
                    res_next = inv_val;
                end
                else if (func_reg == FUNC_SBOX)
                begin
                    res_next = aes_affine(inv_val);
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_reg <= func;
                    a_reg    <= operand_a;
                    b_reg    <= operand_b;
                    r_reg    <= 8'h01;
                    p_reg    <= operand_a;
                end
            end
            ST_MULT:
            begin
                r_reg <= product;
            end
            ST_SQR:
            begin
                p_reg <= product;
            end
            default:
            begin
                r_reg <= r_reg;
            end
        endcase
    end

endmodule

// ===== rtl/core/gf256_alu_with_aes_sbox.sv =====
// Channel   Direction  Handshake             Word contents
// input     in         in_valid / in_stall   func, operand_a, operand_b
// output    out        out_valid / out_stall result_byte
//
// One word is worked at a time; in_stall stays high from acceptance until the
// result has moved into the output register. Inverse and S-box make fifteen
// passes through the one shared multiplier to walk the exponent 254.
// Reset clears the sequencer and the output valid flag.
// A stalled output word holds, and a finished result waits in the core.
module gf256_alu_with_aes_sbox (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic [7:0] operand_a,
    input  logic [7:0] operand_b,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] result_byte
);
    import gfalu_pkg::*;

    resp_t      resp;
    logic       start;
    logic       load;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] result_reg;

    // The core reports busy from the cycle after acceptance until its result
    // has been handed over, so the input side is simply held off while busy.
    assign in_stall = resp.busy;
    assign start    = in_valid && !resp.busy;

    // The output register takes a finished result whenever it is empty or
    // its current word is leaving in this cycle.
    assign load = resp.done && (!out_valid_reg || !out_stall);

    gfalu_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .func      (func_t'(func)),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .ack       (load),
        .resp      (resp)
    );

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= resp.data;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_byte = result_reg;

    // An accepted word keeps the input side stalled in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not held off after acceptance");

    // A finished result never coexists with an idle core.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        resp.done |-> resp.busy)
        else $error("core done while idle");

    // The output word only becomes valid from a finished core result.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(resp.done))
        else $error("output valid without a finished result");

    // A handed-over result releases the core in the next cycle.
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> !resp.busy)
        else $error("core still busy after handing over its result");

endmodule
